// ----- rtl/wgm_pkg.sv -----
// Shared types and constants for the wildcard glob matcher.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] byte_value;
        logic       is_star;
        logic       is_any;
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/wgm_front.sv -----
// Front end: accepts input words and decodes them into operations.
// Depends on wgm_pkg.
`default_nettype none

module wgm_front import wgm_pkg::*; (
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [7:0] s_byte_value,
    output logic            op_valid,
    input  wire logic       op_ready,
    output op_t             op
);

    op_kind_t kind;

    always_comb begin
        unique case (s_command)
            CMD_CLEAR:  kind = OP_CLEAR;
            CMD_APPEND: kind = OP_APPEND;
            CMD_TEXT:   kind = OP_TEXT;
            default:    kind = OP_END;
        endcase
    end

    assign op.kind       = kind;
    assign op.byte_value = s_byte_value;
    assign op.is_star    = (s_byte_value == STAR_BYTE);
    assign op.is_any     = (s_byte_value == ANY_BYTE);
    assign op_valid      = s_valid & aresetn;
    assign s_ready       = op_ready & aresetn;

endmodule

`default_nettype wire

// ----- rtl/wgm_queue.sv -----
// Short operation queue between front end and match engine.
// Depends on wgm_pkg.
`default_nettype none

module wgm_queue import wgm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  op_t       in_op,
    output logic      out_valid,
    input  wire logic out_ready,
    output op_t       out_op
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wgm_back.sv -----
// Match engine: holds the pattern, steps the active-position vector,
// and drives the result register. Depends on wgm_pkg.
`default_nettype none

module wgm_back import wgm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic op_valid,
    output logic      op_ready,
    input  op_t       op,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic      m_matched,
    output logic      m_pattern_overflow
);

    logic [7:0]             pat_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg, star_next;
    logic [MAX_PATTERN-1:0] any_reg, any_next;
    logic [MAX_PATTERN-1:0] lenm_reg, lenm_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   last_star_reg, last_star_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_PATTERN:0]   act_reg, act_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   matched_reg, matched_next;
    logic                   povf_reg, povf_next;

    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] live_star;
    logic [MAX_PATTERN:0]   cur;
    logic [MAX_PATTERN:0]   step;
    logic                   fire;
    logic                   store_we;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            eq_vec[i] = (pat_reg[i] == op.byte_value);
        end
    end

    // Repeated stars are dropped, so closure through '*' is a single shift.
    assign live_star = act_reg[MAX_PATTERN-1:0] & star_reg & lenm_reg;
    assign cur       = act_reg | {live_star, 1'b0};
    assign step      = {1'b0, cur[MAX_PATTERN-1:0] & star_reg & lenm_reg}
                     | {cur[MAX_PATTERN-1:0] & ~star_reg & lenm_reg & (any_reg | eq_vec), 1'b0};

    assign op_ready = aresetn & ((op.kind != OP_END) | ~m_valid_reg | m_ready);
    assign fire     = op_valid & op_ready;

    always_comb begin
        star_next      = star_reg;
        any_next       = any_reg;
        lenm_next      = lenm_reg;
        len_next       = len_reg;
        last_star_next = last_star_reg;
        ovf_next       = ovf_reg;
        act_next       = act_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        matched_next   = matched_reg;
        povf_next      = povf_reg;
        store_we       = 1'b0;
        if (fire) begin
            unique case (op.kind)
                OP_CLEAR: begin
                    len_next       = '0;
                    lenm_next      = '0;
                    last_star_next = 1'b0;
                    ovf_next       = 1'b0;
                    act_next       = (MAX_PATTERN+1)'(1);
                end
                OP_APPEND: begin
                    act_next = (MAX_PATTERN+1)'(1);
                    priority if (ovf_reg) begin
                        ovf_next = 1'b1;
                    end else if (op.is_star && last_star_reg) begin
                        ovf_next = 1'b0;
                    end else if (len_reg >= LEN_W'(MAX_PATTERN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        store_we                = 1'b1;
                        star_next[len_reg[IDX_W-1:0]] = op.is_star;
                        any_next[len_reg[IDX_W-1:0]]  = op.is_any;
                        lenm_next[len_reg[IDX_W-1:0]] = 1'b1;
                        len_next                = len_reg + 1'b1;
                        last_star_next          = op.is_star;
                    end
                end
                OP_TEXT: begin
                    act_next = step;
                end
                OP_END: begin
                    act_next     = (MAX_PATTERN+1)'(1);
                    m_valid_next = 1'b1;
                    matched_next = cur[len_reg] & ~ovf_reg;
                    povf_next    = ovf_reg;
                end
                default: begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lenm_reg      <= '0;
            len_reg       <= '0;
            last_star_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            act_reg       <= (MAX_PATTERN+1)'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            lenm_reg      <= lenm_next;
            len_reg       <= len_next;
            last_star_reg <= last_star_next;
            ovf_reg       <= ovf_next;
            act_reg       <= act_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        star_reg    <= star_next;
        any_reg     <= any_next;
        matched_reg <= matched_next;
        povf_reg    <= povf_next;
        if (store_we) begin
            pat_reg[len_reg[IDX_W-1:0]] <= op.byte_value;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = matched_reg;
    assign m_pattern_overflow = povf_reg;

endmodule

`default_nettype wire

// ----- rtl/wildcard_glob_matcher.sv -----
// Glob matcher top level: front end, operation queue, match engine.
// Throughput: one word per cycle for every command, set by the match engine's update
// of the active-position vector, while no end-of-text word waits for m_ready to take
// the last result. End-of-text results pass the operation queue and result register.
// Reset (aresetn low, synchronous): empty pattern, overflow clear, position 0 active.
// Depends on wgm_pkg, wgm_front, wgm_queue, wgm_back.
`default_nettype none

module wildcard_glob_matcher import wgm_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [7:0] s_byte_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_matched,
    output logic            m_pattern_overflow
);

    logic f_valid, f_ready;
    op_t  f_op;
    logic q_valid, q_ready;
    op_t  q_op;

    wgm_front u_front (
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_byte_value (s_byte_value),
        .op_valid     (f_valid),
        .op_ready     (f_ready),
        .op           (f_op)
    );

    wgm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    wgm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op_valid           (q_valid),
        .op_ready           (q_ready),
        .op                 (q_op),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    a_ovf_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_matched && m_pattern_overflow))
        else $error("match reported with overflowed pattern");

    a_push_fills_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid)
        else $error("accepted word missing from queue");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && q_op.kind == OP_END) |=> m_valid)
        else $error("end of text gave no result");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
